// ===== design/vgsa_pkg.sv =====
// ----------------------------------------------------------------------------
// vgsa_pkg
// Shared types and constants for the voxel grid scatter accumulator.
// ----------------------------------------------------------------------------
package vgsa_pkg;

  // Grid size in cells along each axis
  localparam int CELLS_X = 64;
  localparam int CELLS_Y = 64;
  localparam int CELLS_Z = 64;

  localparam int CX_W = $clog2(CELLS_X);
  localparam int CY_W = $clog2(CELLS_Y);
  localparam int CZ_W = $clog2(CELLS_Z);

  localparam int STRIDE_Y = CELLS_X;
  localparam int STRIDE_Z = CELLS_X * CELLS_Y;

  // Density store
  localparam int IDX_W       = 18;
  localparam int DATA_W      = 32;
  localparam int STORE_DEPTH = 2 ** IDX_W;

  // Queue between front and back
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Register file
  localparam int NUM_REGS = 6;
  localparam int ADDR_W   = $clog2(NUM_REGS * 4);
  localparam logic [DATA_W-1:0] CPU_RESET = 32'h0001_0000;

  typedef enum logic [ADDR_W-3:0] {
    REG_ORG_X,
    REG_ORG_Y,
    REG_ORG_Z,
    REG_CPU_X,
    REG_CPU_Y,
    REG_CPU_Z
  } reg_idx_t;

  typedef struct packed {
    logic signed [31:0] org_x;
    logic signed [31:0] org_y;
    logic signed [31:0] org_z;
    logic [31:0]        cpu_x;
    logic [31:0]        cpu_y;
    logic [31:0]        cpu_z;
  } cfg_t;

  typedef struct packed {
    logic               func;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        power;
    logic [IDX_W-1:0]   read_index;
  } cmd_t;

  typedef struct packed {
    logic [IDX_W-1:0]  voxel_index;
    logic [DATA_W-1:0] read_density;
    logic [DATA_W-1:0] max_density;
    logic              event_dropped;
  } rsp_t;

  localparam logic FUNC_ACC  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  typedef enum logic [1:0] {
    JOB_ACC,
    JOB_READ,
    JOB_DROP
  } job_kind_t;

  typedef struct packed {
    job_kind_t         kind;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] power;
  } job_t;

endpackage

// ===== design/vgsa_ram.sv =====
// ----------------------------------------------------------------------------
// vgsa_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module vgsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/vgsa_regs.sv =====
// ----------------------------------------------------------------------------
// vgsa_regs
// APB register file: grid origin and cells-per-unit per axis.
// ----------------------------------------------------------------------------
module vgsa_regs import vgsa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     regs;
  reg_idx_t sel_idx;
  logic     wr;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign sel_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign cfg     = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.org_x <= '0;
      regs.org_y <= '0;
      regs.org_z <= '0;
      regs.cpu_x <= CPU_RESET;
      regs.cpu_y <= CPU_RESET;
      regs.cpu_z <= CPU_RESET;
    end else if (wr) begin
      case (sel_idx)
        REG_ORG_X: regs.org_x <= pwdata;
        REG_ORG_Y: regs.org_y <= pwdata;
        REG_ORG_Z: regs.org_z <= pwdata;
        REG_CPU_X: regs.cpu_x <= pwdata;
        REG_CPU_Y: regs.cpu_y <= pwdata;
        REG_CPU_Z: regs.cpu_z <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel_idx)
      REG_ORG_X: prdata = regs.org_x;
      REG_ORG_Y: prdata = regs.org_y;
      REG_ORG_Z: prdata = regs.org_z;
      REG_CPU_X: prdata = regs.cpu_x;
      REG_CPU_Y: prdata = regs.cpu_y;
      REG_CPU_Z: prdata = regs.cpu_z;
      default:   prdata = '0;
    endcase
  end

endmodule

// ===== design/vgsa_front.sv =====
// ----------------------------------------------------------------------------
// vgsa_front
// Accepts command words, maps event positions to voxel indexes and
// classifies each word into an accumulate, read or drop job.
// ----------------------------------------------------------------------------
module vgsa_front import vgsa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_stall,
  input  logic clear_busy,
  input  logic pop,
  output logic push,
  output job_t push_job
);

  logic              accept;
  logic [QCNT_W-1:0] credits;
  logic [QCNT_W-1:0] credits_next;

  // stage a: offsets from origin
  logic               a_valid;
  logic               a_func;
  logic [31:0]        a_power;
  logic [IDX_W-1:0]   a_read_index;
  logic signed [32:0] a_diff_x, a_diff_y, a_diff_z;

  // stage b: scaled coordinates
  logic             b_valid;
  logic             b_func;
  logic [31:0]      b_power;
  logic [IDX_W-1:0] b_read_index;
  logic [31:0]      b_hi_x, b_hi_y, b_hi_z;
  logic             b_neg_x, b_neg_y, b_neg_z;
  logic             b_czero_x, b_czero_y, b_czero_z;

  logic [63:0]      prod_x, prod_y, prod_z;
  logic             ok_x, ok_y, ok_z;
  logic [CX_W-1:0]  cell_x;
  logic [CY_W-1:0]  cell_y;
  logic [CZ_W-1:0]  cell_z;
  logic [IDX_W-1:0] lin;

  // credits cover every word between accept and queue pop, so no stage stalls
  assign accept       = cmd_valid && !cmd_stall;
  assign cmd_stall    = clear_busy || (credits == QCNT_W'(QDEPTH));
  assign credits_next = credits + QCNT_W'(accept) - QCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      credits <= '0;
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      credits <= credits_next;
      a_valid <= accept;
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_func       <= cmd.func;
      a_power      <= cmd.power;
      a_read_index <= cmd.read_index;
      a_diff_x     <= $signed({cmd.pos_x[31], cmd.pos_x}) - $signed({cfg.org_x[31], cfg.org_x});
      a_diff_y     <= $signed({cmd.pos_y[31], cmd.pos_y}) - $signed({cfg.org_y[31], cfg.org_y});
      a_diff_z     <= $signed({cmd.pos_z[31], cmd.pos_z}) - $signed({cfg.org_z[31], cfg.org_z});
    end
  end

  // a non-negative offset fits in 32 unsigned bits
  assign prod_x = 64'(a_diff_x[31:0]) * 64'(cfg.cpu_x);
  assign prod_y = 64'(a_diff_y[31:0]) * 64'(cfg.cpu_y);
  assign prod_z = 64'(a_diff_z[31:0]) * 64'(cfg.cpu_z);

  always_ff @(posedge clk) begin
    b_func       <= a_func;
    b_power      <= a_power;
    b_read_index <= a_read_index;
    b_hi_x       <= prod_x[63:32];
    b_hi_y       <= prod_y[63:32];
    b_hi_z       <= prod_z[63:32];
    b_neg_x      <= a_diff_x[32];
    b_neg_y      <= a_diff_y[32];
    b_neg_z      <= a_diff_z[32];
    b_czero_x    <= (cfg.cpu_x == '0);
    b_czero_y    <= (cfg.cpu_y == '0);
    b_czero_z    <= (cfg.cpu_z == '0);
  end

  // below the origin only a zero scale lands in the grid, at cell zero
  assign ok_x   = b_neg_x ? b_czero_x : (b_hi_x < 32'(CELLS_X));
  assign ok_y   = b_neg_y ? b_czero_y : (b_hi_y < 32'(CELLS_Y));
  assign ok_z   = b_neg_z ? b_czero_z : (b_hi_z < 32'(CELLS_Z));
  assign cell_x = b_neg_x ? '0 : b_hi_x[CX_W-1:0];
  assign cell_y = b_neg_y ? '0 : b_hi_y[CY_W-1:0];
  assign cell_z = b_neg_z ? '0 : b_hi_z[CZ_W-1:0];

  // index wraps modulo the store depth
  assign lin = IDX_W'(cell_x)
             + IDX_W'(IDX_W'(STRIDE_Y) * IDX_W'(cell_y))
             + IDX_W'(IDX_W'(STRIDE_Z) * IDX_W'(cell_z));

  assign push = b_valid;

  always_comb begin
    push_job.power = b_power;
    if (b_func == FUNC_READ) begin
      push_job.kind = JOB_READ;
      push_job.idx  = b_read_index;
    end else if (ok_x && ok_y && ok_z) begin
      push_job.kind = JOB_ACC;
      push_job.idx  = lin;
    end else begin
      push_job.kind = JOB_DROP;
      push_job.idx  = '0;
    end
  end

endmodule

// ===== design/vgsa_queue.sv =====
// ----------------------------------------------------------------------------
// vgsa_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module vgsa_queue import vgsa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head,
  output logic nonempty
);

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign head     = slots[rd_ptr];
  assign nonempty = (count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + QCNT_W'(push) - QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

endmodule

// ===== design/vgsa_back.sv =====
// ----------------------------------------------------------------------------
// vgsa_back
// Executes jobs against the density store: read-modify-write with
// forwarding, saturating add, running maximum and the result register.
// Clears the store after reset.
// ----------------------------------------------------------------------------
module vgsa_back import vgsa_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  job_t head,
  input  logic nonempty,
  output logic pop,
  output logic clear_busy,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  logic              clr_busy;
  logic [IDX_W-1:0]  clr_addr;

  logic              s1_valid;
  job_t              s1_job;
  logic              advance;

  logic              fwd_valid;
  logic [IDX_W-1:0]  fwd_idx;
  logic [DATA_W-1:0] fwd_data;

  logic [DATA_W-1:0] running_max;
  logic [DATA_W-1:0] ram_rdata;
  logic [DATA_W-1:0] base;
  logic [DATA_W:0]   sum;
  logic [DATA_W-1:0] nd;
  logic [DATA_W-1:0] max_new;
  rsp_t              result;

  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [DATA_W-1:0] wdata;

  assign clear_busy = clr_busy;
  assign advance    = s1_valid && (!rsp_valid || !rsp_stall);
  assign pop        = nonempty && !clr_busy && (!s1_valid || advance);

  // sweep the store once after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == IDX_W'(STORE_DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end
    end
  end

  // the read misses only the write made at the same edge: forward it
  assign base    = (fwd_valid && (fwd_idx == s1_job.idx)) ? fwd_data : ram_rdata;
  assign sum     = {1'b0, base} + {1'b0, s1_job.power};
  assign nd      = sum[DATA_W] ? '1 : sum[DATA_W-1:0];
  assign max_new = (nd > running_max) ? nd : running_max;

  always_comb begin
    case (s1_job.kind)
      JOB_ACC: begin
        result.voxel_index   = s1_job.idx;
        result.read_density  = nd;
        result.max_density   = max_new;
        result.event_dropped = 1'b0;
      end
      JOB_READ: begin
        result.voxel_index   = s1_job.idx;
        result.read_density  = base;
        result.max_density   = running_max;
        result.event_dropped = 1'b0;
      end
      default: begin
        result.voxel_index   = '0;
        result.read_density  = '0;
        result.max_density   = running_max;
        result.event_dropped = 1'b1;
      end
    endcase
  end

  assign we    = clr_busy || (advance && (s1_job.kind == JOB_ACC));
  assign waddr = clr_busy ? clr_addr : s1_job.idx;
  assign wdata = clr_busy ? '0 : nd;

  vgsa_ram #(
    .WIDTH (DATA_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (pop),
    .raddr (head.idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      fwd_valid   <= 1'b0;
      rsp_valid   <= 1'b0;
      running_max <= '0;
    end else begin
      if (pop) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      // hold the forward word while the job waits on the result register
      if (advance) begin
        fwd_valid <= (s1_job.kind == JOB_ACC);
        if (s1_job.kind == JOB_ACC) begin
          running_max <= max_new;
        end
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_job <= head;
    end
    if (advance) begin
      fwd_idx  <= s1_job.idx;
      fwd_data <= nd;
      rsp      <= result;
    end
  end

endmodule

// ===== design/voxel_grid_scatter_accumulate.sv =====
// ----------------------------------------------------------------------------
// voxel_grid_scatter_accumulate
// A command word passes the offset and scale stages, the job queue and the execute stage before its result turns valid.
// Throughput: one word per cycle while cmd_stall and rsp_stall stay low, also for repeated hits on the same voxel.
// Queue credits cap the words between the input and the execute stage at eight.
// Reset clears the density store; cmd_stall stays high until the sweep is done.
// ----------------------------------------------------------------------------
module voxel_grid_scatter_accumulate import vgsa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  cmd_t              cmd,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output rsp_t              rsp
);

  cfg_t cfg;
  logic clear_busy;
  logic push;
  job_t push_job;
  logic pop;
  job_t head;
  logic nonempty;

  vgsa_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  vgsa_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .cmd_valid  (cmd_valid),
    .cmd        (cmd),
    .cmd_stall  (cmd_stall),
    .clear_busy (clear_busy),
    .pop        (pop),
    .push       (push),
    .push_job   (push_job)
  );

  vgsa_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .nonempty (nonempty)
  );

  vgsa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .nonempty   (nonempty),
    .pop        (pop),
    .clear_busy (clear_busy),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule
